>>> hw/rtl/depthwise_conv_3x3_stream_top_assert.svh
// ----------------------------------------------------------------------------
// Assertion macros for the depthwise 3x3 convolution block
// Each macro expands to one labelled concurrent assertion on i_clk.
// ----------------------------------------------------------------------------
`ifndef DEPTHWISE_CONV_3X3_STREAM_TOP_ASSERT_SVH
`define DEPTHWISE_CONV_3X3_STREAM_TOP_ASSERT_SVH

// Implication in the same cycle, ignored while reset is held
`define DWC_ASSERT_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("dwc assertion failed");

// Condition that must hold in the cycle after any clock edge at which reset is held
`define DWC_ASSERT_RST(lbl, cons) \
    lbl: assert property (@(posedge i_clk) !i_rst_n |=> (cons)) \
        else $error("dwc reset assertion failed");

`endif

>>> hw/rtl/dwc_pkg.sv
// ----------------------------------------------------------------------------
// dwc_pkg
// Shared types and constants of the depthwise 3x3 convolution block.
// ----------------------------------------------------------------------------
package dwc_pkg;

    // kernel geometry
    localparam int TAPS      = 9;
    localparam int ROW_LIMIT = 128;

    // field widths
    localparam int SAMPLE_W  = 16;
    localparam int PROD_W    = 32;
    localparam int PART_W    = 34;
    localparam int VALUE_W   = 36;
    localparam int ROW_W     = 7;
    localparam int OUT_CH_W  = 4;
    localparam int BANK_W    = 4;

    // configuration port
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 8;

    localparam logic [7:0] PAD_W_RESET = 8'd16;
    localparam logic [7:0] PAD_H_RESET = 8'd16;
    localparam logic [1:0] STEP_RESET  = 2'd1;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_PADDED_WIDTH  = 2'd0,
        REG_PADDED_HEIGHT = 2'd1,
        REG_STEP_SIZE     = 2'd2
    } t_cfg_reg;

    typedef logic signed [SAMPLE_W-1:0] t_sample;
    typedef logic signed [PROD_W-1:0]   t_product;
    typedef logic signed [PART_W-1:0]   t_partial;
    typedef logic signed [VALUE_W-1:0]  t_value;

    // position tags of one result
    typedef struct packed {
        logic [OUT_CH_W-1:0] out_channel;
        logic [ROW_W-1:0]    out_row;
        logic [ROW_W-1:0]    out_col;
        logic                frame_last;
    } t_meta;

    // first pipeline stage: result pending plus its tags
    typedef struct packed {
        logic  valid;
        t_meta meta;
    } t_stage;

endpackage

>>> hw/rtl/dwc_stream_if.sv
// ----------------------------------------------------------------------------
// dwc_stream_if
// Valid/ready channels of the block: item input and result output.
// ----------------------------------------------------------------------------
interface dwc_in_if import dwc_pkg::*; ();
    logic    valid;
    logic    ready;
    logic    op;
    logic [3:0] channel;
    logic [3:0] tap;
    t_sample sample;

    modport source (output valid, output op, output channel, output tap,
                    output sample, input ready);
    modport sink   (input valid, input op, input channel, input tap,
                    input sample, output ready);
endinterface

interface dwc_out_if import dwc_pkg::*; ();
    logic                valid;
    logic                ready;
    logic [OUT_CH_W-1:0] out_channel;
    logic [ROW_W-1:0]    out_row;
    logic [ROW_W-1:0]    out_col;
    t_value              out_value;
    logic                frame_last;

    modport source (output valid, output out_channel, output out_row, output out_col,
                    output out_value, output frame_last, input ready);
    modport sink   (input valid, input out_channel, input out_row, input out_col,
                    input out_value, input frame_last, output ready);
endinterface

>>> hw/rtl/depthwise_conv_3x3_stream_top.sv
// ----------------------------------------------------------------------------
// depthwise_conv_3x3_stream_top
// Streaming depthwise 3x3 convolution over a padded, channel-interleaved image.
// ----------------------------------------------------------------------------
// Usage:
//   i_in carries items: op=0 loads one weight (channel, tap), op=1 pushes one
//   pixel sample in raster order, channel fastest. o_out carries one result
//   per pixel that closes a 3x3 window on the stride grid; frame_last marks
//   the final one of the frame. i_cfg_we/i_cfg_idx/i_cfg_data set padded
//   width, padded height and stride; write them only while the block is idle.
//   Throughput is one item per cycle unless o_out stalls. The line buffer and
//   weight memory reads are registered at the edge that accepts a pixel; the
//   nine products, the row sums and the final sum are then registered in
//   turn, and the final sum register is the output register. The
//   nine line buffer banks each give one read per cycle, which is what allows
//   a full window per item. Reset clears the position counters, the pipeline
//   valid bits and the geometry to 16 x 16, stride 1; weights and line
//   contents are not cleared and need no clearing pass. While a result waits
//   on o_out.ready the whole pipe holds and i_in.ready is low.
// ----------------------------------------------------------------------------
`include "depthwise_conv_3x3_stream_top_assert.svh"

module depthwise_conv_3x3_stream_top import dwc_pkg::*; #(
    parameter int CHANNELS  = 16,
    parameter int MAX_WIDTH = 128
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    dwc_in_if.sink                i_in,
    dwc_out_if.source             o_out
);

    localparam int CW = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
    localparam int AW = $clog2(((MAX_WIDTH + 2) / 3) * CHANNELS);
    localparam logic [OUT_CH_W-1:0] CH_TOP = OUT_CH_W'(CHANNELS - 1);

    logic              en;
    logic              acc;
    logic [CW-1:0]     cur_ch;
    logic              wr_en;
    logic [BANK_W-1:0] wr_bank;
    logic [AW-1:0]     wr_addr;
    logic [AW-1:0]     rd_addr [3];
    logic [BANK_W-1:0] tap_bank [TAPS-1];
    t_stage            s1;
    t_sample           pix [TAPS];
    t_sample           wt [TAPS];
    t_meta             res_meta;

    // take a transaction whenever the pipe can move
    assign i_in.ready = en;
    assign acc        = i_in.valid && en;

    dwc_pos #(
        .CHANNELS  (CHANNELS),
        .MAX_WIDTH (MAX_WIDTH)
    ) u_pos (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_acc      (acc),
        .i_en       (en),
        .i_op       (i_in.op),
        .o_ch       (cur_ch),
        .o_wr_en    (wr_en),
        .o_wr_bank  (wr_bank),
        .o_wr_addr  (wr_addr),
        .o_rd_addr  (rd_addr),
        .o_tap_bank (tap_bank),
        .o_s1       (s1)
    );

    dwc_line_buf #(
        .CHANNELS  (CHANNELS),
        .MAX_WIDTH (MAX_WIDTH)
    ) u_line (
        .i_clk      (i_clk),
        .i_wr_en    (wr_en),
        .i_wr_bank  (wr_bank),
        .i_wr_addr  (wr_addr),
        .i_rd_en    (acc),
        .i_rd_addr  (rd_addr),
        .i_tap_bank (tap_bank),
        .i_sample   (i_in.sample),
        .o_pix      (pix)
    );

    dwc_wgt_buf #(
        .CHANNELS (CHANNELS)
    ) u_wgt (
        .i_clk     (i_clk),
        .i_wr_en   (acc && !i_in.op),
        .i_channel (i_in.channel),
        .i_tap     (i_in.tap),
        .i_sample  (i_in.sample),
        .i_rd_en   (acc),
        .i_rd_ch   (cur_ch),
        .o_wt      (wt)
    );

    dwc_mac u_mac (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_s1    (s1),
        .i_pix   (pix),
        .i_wt    (wt),
        .i_ready (o_out.ready),
        .o_en    (en),
        .o_valid (o_out.valid),
        .o_meta  (res_meta),
        .o_value (o_out.out_value)
    );

    // present the result tags
    assign o_out.out_channel = res_meta.out_channel;
    assign o_out.out_row     = res_meta.out_row;
    assign o_out.out_col     = res_meta.out_col;
    assign o_out.frame_last  = res_meta.frame_last;

    // checks
    `DWC_ASSERT_IMP(a_stall_blocks_input, o_out.valid && !o_out.ready, !i_in.ready)
    `DWC_ASSERT_IMP(a_last_on_top_channel, o_out.valid && o_out.frame_last, o_out.out_channel == CH_TOP)
    `DWC_ASSERT_IMP(a_result_held, $past(o_out.valid && !o_out.ready), o_out.valid)
    `DWC_ASSERT_RST(a_reset_empties_output, !o_out.valid)

endmodule

>>> hw/rtl/dwc_pos.sv
// ----------------------------------------------------------------------------
// dwc_pos
// Geometry registers, pixel position counters and line buffer addressing.
// ----------------------------------------------------------------------------
module dwc_pos import dwc_pkg::*; #(
    parameter int CHANNELS  = 16,
    parameter int MAX_WIDTH = 128
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    input  logic                  i_acc,
    input  logic                  i_en,
    input  logic                  i_op,
    output logic [((CHANNELS > 1) ? $clog2(CHANNELS) : 1)-1:0] o_ch,
    output logic                  o_wr_en,
    output logic [BANK_W-1:0]     o_wr_bank,
    output logic [$clog2(((MAX_WIDTH + 2) / 3) * CHANNELS)-1:0] o_wr_addr,
    output logic [$clog2(((MAX_WIDTH + 2) / 3) * CHANNELS)-1:0] o_rd_addr [3],
    output logic [BANK_W-1:0]     o_tap_bank [TAPS-1],
    output t_stage                o_s1
);

    localparam int CW = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
    localparam int XW = $clog2(MAX_WIDTH);
    localparam int QD = (MAX_WIDTH + 2) / 3;
    localparam int QW = (QD > 1) ? $clog2(QD) : 1;
    localparam int AW = $clog2(QD * CHANNELS);
    localparam int WW = $clog2(MAX_WIDTH + 1);
    localparam int GW = (WW > 8) ? WW : 8;
    localparam logic [CW-1:0] CH_LAST = CW'(CHANNELS - 1);

    // sum of two residues, reduced modulo three
    function automatic logic [1:0] mod3_sum(input logic [1:0] a, input logic [2:0] b);
        logic [2:0] x;
        x = {1'b0, a} + b;
        return (x >= 3'd3) ? 2'(x - 3'd3) : x[1:0];
    endfunction

    logic [7:0]       r_pad_w;
    logic [7:0]       r_pad_h;
    logic [1:0]       r_step;
    logic [XW-1:0]    r_col,   n_col;
    logic [1:0]       r_col_m, n_col_m;
    logic [QW-1:0]    r_col_q, n_col_q;
    logic [ROW_W-1:0] r_row,   n_row;
    logic [1:0]       r_row_m, n_row_m;
    logic [CW-1:0]    r_chan,  n_chan;
    t_stage           r_s1;

    logic [GW-1:0]    pw_x, w_eff, w_m3, last_c;
    logic [7:0]       h_eff, h_m3, last_r;
    logic             st2;
    logic             emit;
    logic [XW-1:0]    c_m2;
    logic [ROW_W-1:0] r_m2;
    t_meta            meta;
    logic [1:0]       back [3];
    logic [QW-1:0]    col_q [3];

    // hold the geometry registers; unknown indexes are dropped
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pad_w <= PAD_W_RESET;
            r_pad_h <= PAD_H_RESET;
            r_step  <= STEP_RESET;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                REG_PADDED_WIDTH:  r_pad_w <= i_cfg_data;
                REG_PADDED_HEIGHT: r_pad_h <= i_cfg_data;
                REG_STEP_SIZE:     r_step  <= i_cfg_data[1:0];
                default: ;
            endcase
        end
    end

    // saturate the geometry to its legal range
    always_comb begin
        pw_x = GW'(r_pad_w);
        if (pw_x < GW'(3))              w_eff = GW'(3);
        else if (pw_x > GW'(MAX_WIDTH)) w_eff = GW'(MAX_WIDTH);
        else                            w_eff = pw_x;
        if (r_pad_h < 8'd3)                      h_eff = 8'd3;
        else if ({1'b0, r_pad_h} > 9'(ROW_LIMIT)) h_eff = 8'(ROW_LIMIT);
        else                                     h_eff = r_pad_h;
        st2    = r_step[1];
        w_m3   = w_eff - GW'(3);
        h_m3   = h_eff - 8'd3;
        last_c = st2 ? GW'(2) + {w_m3[GW-1:1], 1'b0} : w_eff - GW'(1);
        last_r = st2 ? 8'd2 + {h_m3[7:1], 1'b0} : h_eff - 8'd1;
    end

    // advance the position: channel fastest, then column, then row
    always_comb begin
        n_chan  = r_chan;
        n_col   = r_col;
        n_col_m = r_col_m;
        n_col_q = r_col_q;
        n_row   = r_row;
        n_row_m = r_row_m;
        if (r_chan == CH_LAST) begin
            n_chan = '0;
            if (GW'(r_col) + GW'(1) >= w_eff) begin
                n_col   = '0;
                n_col_m = 2'd0;
                n_col_q = '0;
                if ({1'b0, r_row} + 8'd1 >= h_eff) begin
                    n_row   = '0;
                    n_row_m = 2'd0;
                end else begin
                    n_row   = r_row + ROW_W'(1);
                    n_row_m = (r_row_m == 2'd2) ? 2'd0 : r_row_m + 2'd1;
                end
            end else begin
                n_col = r_col + XW'(1);
                if (r_col_m == 2'd2) begin
                    n_col_m = 2'd0;
                    n_col_q = r_col_q + QW'(1);
                end else begin
                    n_col_m = r_col_m + 2'd1;
                end
            end
        end else begin
            n_chan = r_chan + CW'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_chan  <= '0;
            r_col   <= '0;
            r_col_m <= 2'd0;
            r_col_q <= '0;
            r_row   <= '0;
            r_row_m <= 2'd0;
        end else if (i_acc && i_op) begin
            r_chan  <= n_chan;
            r_col   <= n_col;
            r_col_m <= n_col_m;
            r_col_q <= n_col_q;
            r_row   <= n_row;
            r_row_m <= n_row_m;
        end
    end

    // window completion on the stride grid, and the result tags
    always_comb begin
        c_m2 = r_col - XW'(2);
        r_m2 = r_row - ROW_W'(2);
        emit = (r_row >= ROW_W'(2)) && (r_col >= XW'(2))
            && (!st2 || (!r_row[0] && !r_col[0]));
        meta.out_channel = OUT_CH_W'(r_chan);
        meta.out_row     = ROW_W'(r_m2 >> st2);
        meta.out_col     = ROW_W'(c_m2 >> st2);
        meta.frame_last  = ({1'b0, r_row} == last_r) && (GW'(r_col) == last_c)
            && (r_chan == CH_LAST);
    end

    // load the first stage: valid follows the pipe, tags follow the transaction
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1.valid <= 1'b0;
        end else if (i_en) begin
            r_s1.valid <= i_acc && i_op && emit;
        end
        if (i_acc) begin
            r_s1.meta <= meta;
        end
    end

    // bank addresses: column residue m holds one of columns c-2 .. c
    always_comb begin
        for (int m = 0; m < 3; m++) begin
            back[m] = mod3_sum(r_col_m, 3'(3 - m));
            if (r_col_m >= back[m])  col_q[m] = r_col_q;
            else if (r_col_q == '0)  col_q[m] = '0;
            else                     col_q[m] = r_col_q - QW'(1);
            o_rd_addr[m] = AW'(32'(col_q[m]) * CHANNELS + 32'(r_chan));
        end
    end

    // bank that feeds each window tap; the newest tap comes from the input
    always_comb begin
        for (int i = 0; i < 3; i++) begin
            for (int j = 0; j < 3; j++) begin
                if (i * 3 + j < TAPS - 1) begin
                    o_tap_bank[i * 3 + j] =
                        {2'b00, mod3_sum(r_row_m, 3'(1 + i))} * BANK_W'(3)
                        + {2'b00, mod3_sum(r_col_m, 3'(1 + j))};
                end
            end
        end
    end

    assign o_ch      = r_chan;
    assign o_wr_en   = i_acc && i_op;
    assign o_wr_bank = {2'b00, r_row_m} * BANK_W'(3) + {2'b00, r_col_m};
    assign o_wr_addr = AW'(32'(r_col_q) * CHANNELS + 32'(r_chan));
    assign o_s1      = r_s1;

endmodule

>>> hw/rtl/dwc_line_buf.sv
// ----------------------------------------------------------------------------
// dwc_line_buf
// Three-row line buffer in nine banks, by row slot and column residue.
// ----------------------------------------------------------------------------
module dwc_line_buf import dwc_pkg::*; #(
    parameter int CHANNELS  = 16,
    parameter int MAX_WIDTH = 128
) (
    input  logic              i_clk,
    input  logic              i_wr_en,
    input  logic [BANK_W-1:0] i_wr_bank,
    input  logic [$clog2(((MAX_WIDTH + 2) / 3) * CHANNELS)-1:0] i_wr_addr,
    input  logic              i_rd_en,
    input  logic [$clog2(((MAX_WIDTH + 2) / 3) * CHANNELS)-1:0] i_rd_addr [3],
    input  logic [BANK_W-1:0] i_tap_bank [TAPS-1],
    input  t_sample           i_sample,
    output t_sample           o_pix [TAPS]
);

    localparam int BD = ((MAX_WIDTH + 2) / 3) * CHANNELS;

    t_sample          r_mem [TAPS][BD];
    t_sample          r_rd [TAPS];
    logic [BANK_W-1:0] r_sel [TAPS-1];
    t_sample          r_sample;

    // write the arriving pixel, read every bank at its window column
    always_ff @(posedge i_clk) begin
        for (int b = 0; b < TAPS; b++) begin
            if (i_wr_en && (i_wr_bank == BANK_W'(b))) begin
                r_mem[b][i_wr_addr] <= i_sample;
            end
            if (i_rd_en) begin
                r_rd[b] <= r_mem[b][i_rd_addr[b % 3]];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_sel    <= i_tap_bank;
            r_sample <= i_sample;
        end
    end

    // route banks onto window taps; the newest tap is the pixel itself
    always_comb begin
        for (int t = 0; t < TAPS - 1; t++) begin
            o_pix[t] = r_rd[r_sel[t]];
        end
        o_pix[TAPS-1] = r_sample;
    end

endmodule

>>> hw/rtl/dwc_wgt_buf.sv
// ----------------------------------------------------------------------------
// dwc_wgt_buf
// Kernel weight store: one memory per tap, addressed by channel.
// ----------------------------------------------------------------------------
module dwc_wgt_buf import dwc_pkg::*; #(
    parameter int CHANNELS = 16
) (
    input  logic       i_clk,
    input  logic       i_wr_en,
    input  logic [3:0] i_channel,
    input  logic [3:0] i_tap,
    input  t_sample    i_sample,
    input  logic       i_rd_en,
    input  logic [((CHANNELS > 1) ? $clog2(CHANNELS) : 1)-1:0] i_rd_ch,
    output t_sample    o_wt [TAPS]
);

    localparam int CW = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;

    t_sample       r_mem [TAPS][CHANNELS];
    t_sample       r_wt [TAPS];
    logic          wr_ok;
    logic [CW-1:0] wr_idx;

    // drop weights aimed at a tap or channel that does not exist
    assign wr_ok  = i_wr_en && (32'(i_channel) < CHANNELS) && (i_tap < 4'(TAPS));
    assign wr_idx = CW'(i_channel);

    always_ff @(posedge i_clk) begin
        for (int t = 0; t < TAPS; t++) begin
            if (wr_ok && (i_tap == 4'(t))) begin
                r_mem[t][wr_idx] <= i_sample;
            end
            if (i_rd_en) begin
                r_wt[t] <= r_mem[t][i_rd_ch];
            end
        end
    end

    assign o_wt = r_wt;

endmodule

>>> hw/rtl/dwc_mac.sv
// ----------------------------------------------------------------------------
// dwc_mac
// Nine parallel products and two adder stages, the second being the result register.
// ----------------------------------------------------------------------------
module dwc_mac import dwc_pkg::*; (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  t_stage  i_s1,
    input  t_sample i_pix [TAPS],
    input  t_sample i_wt [TAPS],
    input  logic    i_ready,
    output logic    o_en,
    output logic    o_valid,
    output t_meta   o_meta,
    output t_value  o_value
);

    t_product r_prod [TAPS];
    t_partial r_part [3];
    t_value   r_value;
    logic     r_v2, r_v3, r_v4;
    t_meta    r_m2, r_m3, r_m4;
    logic     en;

    // advance the whole pipe unless the result waits on the receiver
    assign en = !r_v4 || i_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
            r_v4 <= 1'b0;
        end else if (en) begin
            r_v2 <= i_s1.valid;
            r_v3 <= r_v2;
            r_v4 <= r_v3;
        end
    end

    // multiply, sum by rows, then sum the rows
    always_ff @(posedge i_clk) begin
        if (en) begin
            for (int t = 0; t < TAPS; t++) begin
                r_prod[t] <= i_pix[t] * i_wt[t];
            end
            for (int g = 0; g < 3; g++) begin
                r_part[g] <= PART_W'(r_prod[3 * g]) + PART_W'(r_prod[3 * g + 1])
                           + PART_W'(r_prod[3 * g + 2]);
            end
            r_value <= VALUE_W'(r_part[0]) + VALUE_W'(r_part[1]) + VALUE_W'(r_part[2]);
            r_m2    <= i_s1.meta;
            r_m3    <= r_m2;
            r_m4    <= r_m3;
        end
    end

    assign o_en    = en;
    assign o_valid = r_v4;
    assign o_meta  = r_m4;
    assign o_value = r_value;

endmodule

>>> test/tb_depthwise_conv_3x3_stream_top.sv
// ----------------------------------------------------------------------------
// tb_depthwise_conv_3x3_stream_top
// Self-checking bench for the streaming depthwise 3x3 convolution. Kernels and
// padded frames are queued and driven with random sender and receiver gaps.
// Every accepted item updates a cycle-free model of the kernels, line rows and
// raster position. Each result is compared with the oldest predicted window sum.
// ----------------------------------------------------------------------------
module tb_depthwise_conv_3x3_stream_top;
    import dwc_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int CHANS          = 16;
    localparam int MAX_W          = 128;
    localparam int PIPE_DRAIN     = 8;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int MAX_REPORTS    = 10;

    localparam logic OP_WEIGHT = 1'b0;
    localparam logic OP_PIXEL  = 1'b1;
    // index with no register behind it; writes to it must be ignored
    localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 2'd3;

    typedef enum int {FILL_RANDOM, FILL_MIN, FILL_MAX, FILL_EXTREME} t_fill;

    typedef struct packed {
        logic       op;
        logic [3:0] channel;
        logic [3:0] tap;
        t_sample    sample;
    } t_conv_item;

    typedef struct packed {
        logic [OUT_CH_W-1:0] out_channel;
        logic [ROW_W-1:0]    out_row;
        logic [ROW_W-1:0]    out_col;
        t_value              out_value;
        logic                frame_last;
    } t_window_res;

    logic i_clk   = 1'b0;
    logic i_rst_n = 1'b0;

    logic                  cfg_we   = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_idx  = '0;
    logic [CFG_DATA_W-1:0] cfg_data = '0;
    logic                  drv_valid = 1'b0;
    t_conv_item            drv_item  = '0;
    logic                  snk_ready = 1'b0;

    dwc_in_if  in_if ();
    dwc_out_if out_if ();

    assign in_if.valid   = drv_valid;
    assign in_if.op      = drv_item.op;
    assign in_if.channel = drv_item.channel;
    assign in_if.tap     = drv_item.tap;
    assign in_if.sample  = drv_item.sample;
    assign out_if.ready  = snk_ready;

    depthwise_conv_3x3_stream_top #(
        .CHANNELS  (CHANS),
        .MAX_WIDTH (MAX_W)
    ) u_top (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (cfg_we),
        .i_cfg_idx  (cfg_idx),
        .i_cfg_data (cfg_data),
        .i_in       (in_if),
        .o_out      (out_if)
    );

    // 4 ns clock
    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    // stimulus store and expected window sums
    t_conv_item  pending_items[$];
    t_window_res expected_windows[$];

    // model state: kernels, three line rows, raster position, geometry
    t_sample        kernel_mem [CHANS*TAPS];
    t_sample        line_mem   [3*MAX_W*CHANS];
    logic [ROW_W-1:0] row_pos  = '0;
    logic [ROW_W-1:0] col_pos  = '0;
    logic [3:0]       chan_pos = '0;
    logic [7:0]     cfg_width  = PAD_W_RESET;
    logic [7:0]     cfg_height = PAD_H_RESET;
    logic [1:0]     cfg_step   = STEP_RESET;

    int  src_idle_pct = 0;
    int  snk_idle_pct = 0;
    bit  item_taken   = 1'b0;
    int  outstanding_items = 0;
    int  pushed_items = 0;
    int  n_items = 0, n_weights = 0, n_results = 0, n_frames = 0, n_cfg = 0;
    int  mismatches = 0;
    int  idle_cycles = 0;

    // geometry as the block applies it, out-of-range values saturated
    function automatic int eff_width();
        int v;
        v = cfg_width;
        return (v < 3) ? 3 : (v > MAX_W) ? MAX_W : v;
    endfunction

    function automatic int eff_height();
        int v;
        v = cfg_height;
        return (v < 3) ? 3 : (v > ROW_LIMIT) ? ROW_LIMIT : v;
    endfunction

    function automatic int eff_step();
        return (cfg_step == 2'd0) ? 1 : (cfg_step == 2'd3) ? 2 : int'(cfg_step);
    endfunction

    function automatic int line_addr(input int slot, input int col, input int ch);
        return ((slot % 3) * MAX_W + (col % MAX_W)) * CHANS + ch;
    endfunction

    // advance the raster position: channel fastest, then column, then row
    function automatic void step_pos(inout int r, inout int c, inout int ch,
                                     input int w, input int h);
        if (ch + 1 >= CHANS) begin
            ch = 0;
            if (c + 1 >= w) begin
                c = 0;
                r = (r + 1 >= h) ? 0 : r + 1;
            end else begin
                c = c + 1;
            end
        end else begin
            ch = ch + 1;
        end
    endfunction

    // apply one accepted transaction and queue the window sum it closes
    task automatic predict_window_sum(input t_conv_item it);
        int w, h, st, r, c, ch, last_r, last_c, i, j;
        longint acc;
        t_window_res res;
        w  = eff_width();
        h  = eff_height();
        st = eff_step();
        if (it.op == OP_WEIGHT) begin
            if (it.tap < TAPS && it.channel < CHANS) begin
                kernel_mem[it.channel * TAPS + it.tap] = it.sample;
            end
        end else begin
            r  = row_pos;
            c  = col_pos;
            ch = chan_pos;
            line_mem[line_addr(r, c, ch)] = it.sample;
            if (r >= 2 && c >= 2 && (r - 2) % st == 0 && (c - 2) % st == 0) begin
                acc = 0;
                for (i = 0; i < 3; i++) begin
                    for (j = 0; j < 3; j++) begin
                        acc += longint'(line_mem[line_addr(r + 1 + i, c - 2 + j, ch)])
                             * longint'(kernel_mem[ch * TAPS + i * 3 + j]);
                    end
                end
                last_r = 2 + ((h - 3) / st) * st;
                last_c = 2 + ((w - 3) / st) * st;
                res.out_channel = OUT_CH_W'(ch);
                res.out_row     = ROW_W'((r - 2) / st);
                res.out_col     = ROW_W'((c - 2) / st);
                res.out_value   = t_value'(acc);
                res.frame_last  = (r == last_r && c == last_c && ch == CHANS - 1);
                expected_windows.push_back(res);
            end
            step_pos(r, c, ch, w, h);
            row_pos  = ROW_W'(r);
            col_pos  = ROW_W'(c);
            chan_pos = 4'(ch);
        end
    endtask

    // compare one result transaction with the oldest expectation
    task automatic check_window(input t_window_res got);
        t_window_res want;
        n_results++;
        if (got.frame_last) n_frames++;
        if (expected_windows.size() == 0) begin
            mismatches++;
            if (mismatches <= MAX_REPORTS) begin
                $display("%0t: unexpected result ch %0d row %0d col %0d value %0d last %0b",
                         $realtime, got.out_channel, got.out_row, got.out_col,
                         got.out_value, got.frame_last);
            end
        end else begin
            want = expected_windows.pop_front();
            if (got.out_channel !== want.out_channel || got.out_row !== want.out_row ||
                got.out_col !== want.out_col || got.out_value !== want.out_value ||
                got.frame_last !== want.frame_last) begin
                mismatches++;
                if (mismatches <= MAX_REPORTS) begin
                    $display("%0t: result differs (expected / actual)", $realtime);
                    $display("  ch %0d / %0d  row %0d / %0d  col %0d / %0d",
                             want.out_channel, got.out_channel, want.out_row,
                             got.out_row, want.out_col, got.out_col);
                    $display("  value %0d / %0d  last %0b / %0b", want.out_value,
                             got.out_value, want.frame_last, got.frame_last);
                end
            end
        end
    endtask

    // driver: present the next pending item once the current one is taken
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            drv_valid <= 1'b0;
        end else if (!drv_valid || item_taken) begin
            if (pending_items.size() != 0 && $urandom_range(99) >= src_idle_pct) begin
                drv_item  <= pending_items.pop_front();
                drv_valid <= 1'b1;
            end else begin
                drv_valid <= 1'b0;
            end
        end
        item_taken = 1'b0;
    end

    // receiver: stall the result channel at random
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            snk_ready <= 1'b0;
        end else begin
            snk_ready <= ($urandom_range(99) >= snk_idle_pct);
        end
    end

    // monitor: predict on input transactions, check output transactions
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            idle_cycles++;
            if (in_if.valid && in_if.ready) begin
                item_taken = 1'b1;
                predict_window_sum(drv_item);
                outstanding_items--;
                n_items++;
                if (drv_item.op == OP_WEIGHT) n_weights++;
                idle_cycles = 0;
            end
            if (out_if.valid && out_if.ready) begin
                check_window(t_window_res'{out_if.out_channel, out_if.out_row,
                                           out_if.out_col, out_if.out_value,
                                           out_if.frame_last});
                idle_cycles = 0;
            end
            // give up when nothing moves for too long
            if (idle_cycles >= WATCHDOG_LIMIT) begin
                $display("%0t: watchdog expired, %0d items pending, %0d results awaited",
                         $realtime, outstanding_items, expected_windows.size());
                $display("SCOREBOARD MISMATCH");
                $finish;
            end
        end
    end

    task automatic push_item(input logic op, input logic [3:0] ch, input logic [3:0] tap,
                             input t_sample smp);
        pending_items.push_back(t_conv_item'{op, ch, tap, smp});
        outstanding_items++;
        pushed_items++;
    endtask

    function automatic t_sample pick_sample(input t_fill fill);
        case (fill)
            FILL_MIN: return 16'sh8000;
            FILL_MAX: return 16'sh7fff;
            FILL_EXTREME: begin
                case ($urandom_range(3))
                    0: return 16'sh8000;
                    1: return 16'sh7fff;
                    2: return 16'sh0000;
                    default: return 16'shffff;
                endcase
            end
            default: return t_sample'($urandom);
        endcase
    endfunction

    // write all nine taps of every channel
    task automatic load_kernels(input t_fill fill);
        for (int ch = 0; ch < CHANS; ch++) begin
            for (int t = 0; t < TAPS; t++) begin
                push_item(OP_WEIGHT, 4'(ch), 4'(t), pick_sample(fill));
            end
        end
    endtask

    // pixels with don't-care channel/tap fields, optionally mixed with weight writes
    task automatic push_pixels(input int n, input t_fill fill, input int noise_pct);
        for (int k = 0; k < n; k++) begin
            if ($urandom_range(99) < noise_pct) begin
                push_item(OP_WEIGHT, 4'($urandom_range(15)), 4'($urandom_range(15)),
                          t_sample'($urandom));
            end
            push_item(OP_PIXEL, 4'($urandom_range(15)), 4'($urandom_range(15)),
                      pick_sample(fill));
        end
    endtask

    // one whole frame; only called with the position at the frame start
    task automatic push_frame(input t_fill fill, input int noise_pct);
        push_pixels(eff_width() * eff_height() * CHANS, fill, noise_pct);
    endtask

    // hold until every item is taken and every result is back, then drain the pipe
    task automatic wait_idle();
        while (outstanding_items != 0 || expected_windows.size() != 0) @(negedge i_clk);
        repeat (PIPE_DRAIN) @(negedge i_clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [7:0] data);
        @(negedge i_clk);
        cfg_we   <= 1'b1;
        cfg_idx  <= idx;
        cfg_data <= data;
        case (idx)
            REG_PADDED_WIDTH:  cfg_width  = data;
            REG_PADDED_HEIGHT: cfg_height = data;
            REG_STEP_SIZE:     cfg_step   = data[1:0];
            default: ;
        endcase
        n_cfg++;
    endtask

    task automatic end_writes();
        @(negedge i_clk);
        cfg_we <= 1'b0;
    endtask

    task automatic set_geometry(input logic [7:0] w, input logic [7:0] h,
                                input logic [7:0] st);
        wait_idle();
        write_reg(REG_PADDED_WIDTH, w);
        write_reg(REG_PADDED_HEIGHT, h);
        write_reg(REG_STEP_SIZE, st);
        end_writes();
    endtask

    initial begin : stimulus
        int r, c, ch, remain, leftover;
        src_idle_pct = 13;
        snk_idle_pct = 46;
        repeat (3) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // smallest frame: geometry saturated from below, stride 0 acting as 1,
        // most negative kernels and pixels, plus ignored out-of-range taps
        set_geometry(8'd0, 8'd1, 8'd0);
        load_kernels(FILL_MIN);
        for (int t = TAPS; t < 16; t++) begin
            push_item(OP_WEIGHT, 4'($urandom_range(15)), 4'(t), t_sample'($urandom));
        end
        push_frame(FILL_MIN, 0);

        // swap the idling regime once the first part has drained
        wait_idle();
        src_idle_pct = 46;
        snk_idle_pct = 13;

        // stride 3 acting as 2 with a trailing column after the last result
        set_geometry(8'd4, 8'd3, 8'd3);
        push_pixels(4 * 2 * CHANS + 3 * CHANS + 5, FILL_EXTREME, 5);

        // narrow the row in mid-frame, mid-channel, with the column past the new limit
        wait_idle();
        write_reg(REG_PADDED_WIDTH, 8'd3);
        write_reg(REG_UNUSED, 8'($urandom));
        end_writes();
        r = row_pos;
        c = col_pos;
        ch = chan_pos;
        remain = 0;
        do begin
            remain++;
            step_pos(r, c, ch, eff_width(), eff_height());
        end while (r != 0 || c != 0 || ch != 0);
        push_pixels(remain, FILL_RANDOM, 0);

        // last part without idling: one random small frame back to back
        wait_idle();
        src_idle_pct = 0;
        snk_idle_pct = 0;
        set_geometry(8'($urandom_range(0, 4)), 8'($urandom_range(0, 3)),
                     8'($urandom_range(0, 3)));
        push_frame(($urandom_range(1) == 0) ? FILL_EXTREME : FILL_RANDOM, 8);

        // drain and report
        wait_idle();
        leftover = expected_windows.size();
        $display("%0d items taken (%0d weight writes), %0d window sums over %0d frames",
                 n_items, n_weights, n_results, n_frames);
        $display("%0d register writes, %0d bad results, %0d results never arrived",
                 n_cfg, mismatches, leftover);
        if (mismatches == 0 && leftover == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule
